@@ rtl/core/oriented_box_overlap_test_top_defines.svh @@
// ----------------------------------------------------------------------------
// Oriented box overlap test: assertion macros
// Concurrent check wrappers shared by the core files.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_OVERLAP_TEST_TOP_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// check with reset masking
`define OBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also runs while reset is high
`define OBB_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OBB_ASSERT(lbl, prop, msg)
`define OBB_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ rtl/core/obb_pkg.sv @@
// ----------------------------------------------------------------------------
// Oriented box overlap test: package
// Shared constants, codes and the octant sine/cosine generator.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int COORD_WIDTH_DEF    = 16;
  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int SIZE_W             = 13;
  localparam int ANGLE_W            = 13;
  localparam int IDX_W              = 10;
  localparam int OCT_LAST           = 720;
  localparam int LATENCY            = 10;

  localparam logic [ANGLE_W-1:0] FULL_TURN    = 13'd5760;
  localparam logic [ANGLE_W-1:0] THREE_QUART  = 13'd4320;
  localparam logic [ANGLE_W-1:0] HALF_TURN    = 13'd2880;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 13'd1440;
  localparam logic [ANGLE_W-1:0] EIGHTH_TURN  = 13'd720;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned SIN_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
  localparam longint unsigned COS_DIV [6] = '{64'd132, 64'd90, 64'd56, 64'd30, 64'd12,
                                              64'd2};

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  // width of a doubled centre difference
  function automatic int diff_w(input int cw);
    return ((cw + 1 > 14) ? cw + 1 : 14) + 2;
  endfunction

  // Q30 sine (upper word) and cosine (lower word) of t/16 degree, t in [0, 720];
  // evaluated at elaboration only
  function automatic logic [63:0] trig_q30(input logic [IDX_W-1:0] t);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    x  = (64'(t) * PI_Q30) / 64'd2880;
    x2 = (x * x) >> 30;
    p  = Q30_ONE;
    for (int i = 0; i < 5; i++) p = Q30_ONE - ((x2 * p) >> 30) / SIN_DIV[i];
    s = (x * p) >> 30;
    p = Q30_ONE;
    for (int i = 0; i < 6; i++) p = Q30_ONE - ((x2 * p) >> 30) / COS_DIV[i];
    return {s[31:0], p[31:0]};
  endfunction

endpackage

@@ rtl/core/obb_ifs.sv @@
// ----------------------------------------------------------------------------
// Oriented box overlap test: channel interfaces
// Valid/ready channels for box pairs in and overlap flags out.
// ----------------------------------------------------------------------------
interface obb_in_if #(
  parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [COORD_WIDTH-1:0]     a_left;
  logic signed [COORD_WIDTH-1:0]     a_top;
  logic [obb_pkg::SIZE_W-1:0]        a_width;
  logic [obb_pkg::SIZE_W-1:0]        a_height;
  logic [obb_pkg::ANGLE_W-1:0]       a_angle;
  logic signed [COORD_WIDTH-1:0]     b_left;
  logic signed [COORD_WIDTH-1:0]     b_top;
  logic [obb_pkg::SIZE_W-1:0]        b_width;
  logic [obb_pkg::SIZE_W-1:0]        b_height;
  logic [obb_pkg::ANGLE_W-1:0]       b_angle;

  modport source (output valid, a_left, a_top, a_width, a_height, a_angle,
                  b_left, b_top, b_width, b_height, b_angle, input ready);
  modport sink   (input valid, a_left, a_top, a_width, a_height, a_angle,
                  b_left, b_top, b_width, b_height, b_angle, output ready);
endinterface

interface obb_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink   (input valid, overlap, output ready);
endinterface

@@ rtl/core/obb_trig.sv @@
// ----------------------------------------------------------------------------
// Oriented box overlap test: sine/cosine unit
// Folds the angle to one octant, reads the octant table, applies quadrant.
// ----------------------------------------------------------------------------
`include "oriented_box_overlap_test_top_defines.svh"

module obb_trig #(
  parameter int TRIG_FRAC_BITS = obb_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic [obb_pkg::LATENCY:1]         vld,
  input  logic [obb_pkg::ANGLE_W-1:0]       angle,
  output logic signed [TRIG_FRAC_BITS+1:0]  sin_v,
  output logic signed [TRIG_FRAC_BITS+1:0]  cos_v
);
  localparam int TW = TRIG_FRAC_BITS + 1;
  localparam int SW = TW + 1;
  localparam int SH = 30 - TRIG_FRAC_BITS;
  localparam logic signed [SW-1:0] TRIG_ONE = SW'(64'd1 << TRIG_FRAC_BITS);

  typedef logic [2*TW-1:0] rom_t [0:obb_pkg::OCT_LAST];

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] v;
    for (int t = 0; t <= obb_pkg::OCT_LAST; t++) begin
      v = obb_pkg::trig_q30(obb_pkg::IDX_W'(t));
      r[t] = {TW'((64'(v[63:32]) + (64'd1 << (SH - 1))) >> SH),
              TW'((64'(v[31:0]) + (64'd1 << (SH - 1))) >> SH)};
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [obb_pkg::ANGLE_W-1:0] a_fold;
  logic [10:0]                 rem;
  obb_pkg::quad_t              quad_next, quad, quad3;
  logic [obb_pkg::IDX_W-1:0]   idx_next, idx;
  logic                        swap_next, swap, swap3;
  logic [2*TW-1:0]             rd;
  logic signed [SW-1:0]        bs, bc;

  always_comb begin
    a_fold = (angle >= obb_pkg::FULL_TURN) ? angle - obb_pkg::FULL_TURN : angle;
    if (a_fold < obb_pkg::QUARTER_TURN) begin
      quad_next = obb_pkg::QUAD_0;
      rem       = 11'(a_fold);
    end else if (a_fold < obb_pkg::HALF_TURN) begin
      quad_next = obb_pkg::QUAD_1;
      rem       = 11'(a_fold - obb_pkg::QUARTER_TURN);
    end else if (a_fold < obb_pkg::THREE_QUART) begin
      quad_next = obb_pkg::QUAD_2;
      rem       = 11'(a_fold - obb_pkg::HALF_TURN);
    end else begin
      quad_next = obb_pkg::QUAD_3;
      rem       = 11'(a_fold - obb_pkg::THREE_QUART);
    end
    // upper half of a quadrant mirrors with sine and cosine swapped
    if (rem <= 11'(obb_pkg::EIGHTH_TURN)) begin
      idx_next  = obb_pkg::IDX_W'(rem);
      swap_next = 1'b0;
    end else begin
      idx_next  = obb_pkg::IDX_W'(11'(obb_pkg::QUARTER_TURN) - rem);
      swap_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx   <= idx_next;
      swap  <= swap_next;
      quad  <= quad_next;
      rd    <= ROM[idx];
      swap3 <= swap;
      quad3 <= quad;
    end
  end

  assign bs = $signed({1'b0, swap3 ? rd[TW-1:0] : rd[2*TW-1:TW]});
  assign bc = $signed({1'b0, swap3 ? rd[2*TW-1:TW] : rd[TW-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      case (quad3)
        obb_pkg::QUAD_0: begin sin_v <= bs;  cos_v <= bc;  end
        obb_pkg::QUAD_1: begin sin_v <= bc;  cos_v <= -bs; end
        obb_pkg::QUAD_2: begin sin_v <= -bs; cos_v <= -bc; end
        default:         begin sin_v <= -bc; cos_v <= bs;  end
      endcase
    end
  end

  `OBB_ASSERT(a_idx_range, en && vld[1] |=> idx <= obb_pkg::IDX_W'(obb_pkg::OCT_LAST), "octant index out of range")
  `OBB_ASSERT(a_unit_range, en && vld[3] |=> sin_v <= TRIG_ONE && sin_v >= -TRIG_ONE && cos_v <= TRIG_ONE && cos_v >= -TRIG_ONE, "trig value beyond one")

endmodule

@@ rtl/core/obb_sat.sv @@
// ----------------------------------------------------------------------------
// Oriented box overlap test: separating-axis datapath
// Half-edge vectors, projections, absolute sums and axis compares.
// ----------------------------------------------------------------------------
`include "oriented_box_overlap_test_top_defines.svh"

module obb_sat #(
  parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = obb_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        en,
  input  logic [obb_pkg::LATENCY:1]                   vld,
  input  logic signed [TRIG_FRAC_BITS+1:0]            sin_a,
  input  logic signed [TRIG_FRAC_BITS+1:0]            cos_a,
  input  logic signed [TRIG_FRAC_BITS+1:0]            sin_b,
  input  logic signed [TRIG_FRAC_BITS+1:0]            cos_b,
  input  logic [obb_pkg::SIZE_W-1:0]                  aw,
  input  logic [obb_pkg::SIZE_W-1:0]                  ah,
  input  logic [obb_pkg::SIZE_W-1:0]                  bw,
  input  logic [obb_pkg::SIZE_W-1:0]                  bh,
  input  logic signed [obb_pkg::diff_w(COORD_WIDTH)-1:0] dx,
  input  logic signed [obb_pkg::diff_w(COORD_WIDTH)-1:0] dy,
  output logic                                        overlap
);
  localparam int SW   = TRIG_FRAC_BITS + 2;
  localparam int VW   = TRIG_FRAC_BITS + 14;
  localparam int DW   = obb_pkg::diff_w(COORD_WIDTH);
  localparam int PD   = DW + VW;
  localparam int PV   = 2 * VW;
  localparam int LW   = PD + 1 + TRIG_FRAC_BITS;
  localparam int SUMW = PV + 3;
  localparam int CMPW = (LW > SUMW) ? LW : SUMW;

  function automatic logic signed [VW-1:0] mulv(input logic [obb_pkg::SIZE_W-1:0] m,
                                                input logic signed [SW-1:0] t);
    return VW'($signed({1'b0, m})) * VW'(t);
  endfunction

  function automatic logic [PD:0] mag_d(input logic signed [PD:0] v);
    return v[PD] ? -v : v;
  endfunction

  function automatic logic [PV:0] mag_v(input logic signed [PV:0] v);
    return v[PV] ? -v : v;
  endfunction

  // stage 5: half-edge vectors, order H_a, H_b, W_a, W_b
  logic signed [VW-1:0] vx [4];
  logic signed [VW-1:0] vy [4];
  logic signed [DW-1:0] dx5, dy5;

  always_ff @(posedge clk) begin
    if (en) begin
      vx[0] <= mulv(ah, sin_a);  vy[0] <= -mulv(ah, cos_a);
      vx[1] <= mulv(bh, sin_b);  vy[1] <= -mulv(bh, cos_b);
      vx[2] <= mulv(aw, cos_a);  vy[2] <= mulv(aw, sin_a);
      vx[3] <= mulv(bw, cos_b);  vy[3] <= mulv(bw, sin_b);
      dx5   <= dx;
      dy5   <= dy;
    end
  end

  // stage 6: products; vector pairs only for j >= i (dot is symmetric)
  logic signed [PD-1:0] pdx [4];
  logic signed [PD-1:0] pdy [4];
  logic signed [PV-1:0] pvx [4][4];
  logic signed [PV-1:0] pvy [4][4];

  // stage 7: absolute dots
  logic [PD:0] ld [4];
  logic [PV:0] vv [4][4];

  for (genvar i = 0; i < 4; i++) begin : g_axis
    always_ff @(posedge clk) begin
      if (en) begin
        pdx[i] <= PD'(dx5) * PD'(vx[i]);
        pdy[i] <= PD'(dy5) * PD'(vy[i]);
        ld[i]  <= mag_d((PD+1)'(pdx[i]) + (PD+1)'(pdy[i]));
      end
    end
    for (genvar j = i; j < 4; j++) begin : g_pair
      always_ff @(posedge clk) begin
        if (en) begin
          pvx[i][j] <= PV'(vx[i]) * PV'(vx[j]);
          pvy[i][j] <= PV'(vy[i]) * PV'(vy[j]);
          vv[i][j]  <= mag_v((PV+1)'(pvx[i][j]) + (PV+1)'(pvy[i][j]));
        end
      end
    end
  end

  // stage 8: scaled centre projection and half sums; stage 9: compare
  logic [CMPW-1:0] lhs_r  [4];
  logic [CMPW-1:0] s01_r  [4];
  logic [CMPW-1:0] s23_r  [4];
  logic [3:0]      sep;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        lhs_r[i] <= CMPW'(ld[i]) << TRIG_FRAC_BITS;
        s01_r[i] <= CMPW'(vv[(i < 0) ? i : 0][(i < 0) ? 0 : i])
                  + CMPW'(vv[(i < 1) ? i : 1][(i < 1) ? 1 : i]);
        s23_r[i] <= CMPW'(vv[(i < 2) ? i : 2][(i < 2) ? 2 : i])
                  + CMPW'(vv[(i < 3) ? i : 3][(i < 3) ? 3 : i]);
        sep[i]   <= lhs_r[i] > (s01_r[i] + s23_r[i]);
      end
      overlap <= ~|sep;
    end
  end

  `OBB_ASSERT(a_zero_axis, en && vld[7] && vv[0][0] == '0 |=> lhs_r[0] == '0, "zero axis with nonzero projection")

endmodule

@@ rtl/core/oriented_box_overlap_test_top.sv @@
// ----------------------------------------------------------------------------
// Oriented box overlap test: top level
// Fixed-point separating-axis test of two rotated rectangles, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload
//  --------+-----+------------------------------------------------------
//  boxes   | in  | a_/b_ left, top, width, height, angle (box pair)
//  result  | out | overlap (1 = boxes overlap, 0 = separating axis found)
//
// One box pair per cycle while the output is not stalled; every transfer is
// independent. Ten register stages (input, fold, table read, quadrant, vectors,
// products, magnitudes, sums, compare, output) lie between the input transfer
// and the registered overlap flag on the result channel.
// Reset clears only the stage valid bits; no table clear is needed.
// A stall at the output freezes every stage at once, so nothing is lost or
// repeated, and the input stays ready while the output stage is empty.
//
`include "oriented_box_overlap_test_top_defines.svh"

module oriented_box_overlap_test_top #(
  parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_FRAC_BITS = obb_pkg::TRIG_FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  obb_in_if.sink    boxes,
  obb_out_if.source result
);
  localparam int DW = obb_pkg::diff_w(COORD_WIDTH);
  localparam int SW = TRIG_FRAC_BITS + 2;

  // stage valid bits; bit k marks stage k holding an item
  logic [obb_pkg::LATENCY:1] vld;
  logic                      en;

  // whole pipe moves unless the output holds an untaken result
  assign en          = !vld[obb_pkg::LATENCY] || result.ready;
  assign boxes.ready = en;
  assign result.valid = vld[obb_pkg::LATENCY];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[obb_pkg::LATENCY-1:1], boxes.valid};
    end
  end

  // stage 1: input register
  logic signed [COORD_WIDTH-1:0]  a_left1, a_top1, b_left1, b_top1;
  logic [obb_pkg::SIZE_W-1:0]     aw1, ah1, bw1, bh1;
  logic [obb_pkg::ANGLE_W-1:0]    a_ang1, b_ang1;

  always_ff @(posedge clk) begin
    if (en) begin
      a_left1 <= boxes.a_left;   a_top1 <= boxes.a_top;
      b_left1 <= boxes.b_left;   b_top1 <= boxes.b_top;
      aw1     <= boxes.a_width;  ah1    <= boxes.a_height;
      bw1     <= boxes.b_width;  bh1    <= boxes.b_height;
      a_ang1  <= boxes.a_angle;  b_ang1 <= boxes.b_angle;
    end
  end

  // stages 2..4: doubled centre difference, sizes delayed to the trig output
  logic signed [DW-1:0]       dx2, dy2, dx3, dy3, dx4, dy4;
  logic [obb_pkg::SIZE_W-1:0] aw2, ah2, bw2, bh2, aw3, ah3, bw3, bh3;
  logic [obb_pkg::SIZE_W-1:0] aw4, ah4, bw4, bh4;

  always_ff @(posedge clk) begin
    if (en) begin
      dx2 <= (DW'(a_left1) <<< 1) + DW'($signed({1'b0, aw1}))
           - (DW'(b_left1) <<< 1) - DW'($signed({1'b0, bw1}));
      dy2 <= (DW'(a_top1) <<< 1) + DW'($signed({1'b0, ah1}))
           - (DW'(b_top1) <<< 1) - DW'($signed({1'b0, bh1}));
      dx3 <= dx2;  dy3 <= dy2;  dx4 <= dx3;  dy4 <= dy3;
      aw2 <= aw1;  ah2 <= ah1;  bw2 <= bw1;  bh2 <= bh1;
      aw3 <= aw2;  ah3 <= ah2;  bw3 <= bw2;  bh3 <= bh2;
      aw4 <= aw3;  ah4 <= ah3;  bw4 <= bw3;  bh4 <= bh3;
    end
  end

  logic signed [SW-1:0] sin_a, cos_a, sin_b, cos_b;

  obb_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_a (
    .clk(clk), .rst(rst), .en(en), .vld(vld), .angle(a_ang1),
    .sin_v(sin_a), .cos_v(cos_a)
  );

  obb_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_b (
    .clk(clk), .rst(rst), .en(en), .vld(vld), .angle(b_ang1),
    .sin_v(sin_b), .cos_v(cos_b)
  );

  obb_sat #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sat (
    .clk(clk), .rst(rst), .en(en), .vld(vld),
    .sin_a(sin_a), .cos_a(cos_a), .sin_b(sin_b), .cos_b(cos_b),
    .aw(aw4), .ah(ah4), .bw(bw4), .bh(bh4), .dx(dx4), .dy(dy4),
    .overlap(result.overlap)
  );

  `OBB_ASSERT_NR(a_rst_clear, rst |=> vld == '0, "pipeline not empty after reset")
  `OBB_ASSERT(a_full_stall, vld[obb_pkg::LATENCY] && !result.ready |=> $stable(vld), "stage valids moved during stall")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Oriented box overlap test: testbench
// Streams box pairs through the pipeline under several idle/stall mixes and
// checks every overlap flag against an exact-integer separating-axis model.
// ----------------------------------------------------------------------------
module tb;

  typedef logic signed [127:0] acc_t;

  typedef struct {
    logic signed [15:0] a_left, a_top, b_left, b_top;
    logic [12:0] a_width, a_height, a_angle, b_width, b_height, b_angle;
  } box_pair_t;

  logic clk;
  logic rst;

  obb_in_if  boxes ();
  obb_out_if result ();

  oriented_box_overlap_test_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .boxes  (boxes.sink),
    .result (result.source)
  );

  // Expected overlap flags, oldest first.
  bit overlap_q[$];
  int errors   = 0;
  int idle_pct = 0;   // chance the sender skips a cycle
  int stall_pct = 0;  // chance the receiver holds ready low

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous guard: ends the run with a failure if it hangs.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Overlap predictor
  // --------------------------------------------------------------------------

  // Q30 Taylor series folded into [0, 45] degrees, rounded to Q15.
  function automatic void octant_trig(input longint unsigned t,
                                      output longint s, output longint c);
    longint unsigned x, x2, p;
    longint unsigned sdiv[5] = '{110, 72, 42, 20, 6};
    longint unsigned cdiv[6] = '{132, 90, 56, 30, 12, 2};
    x  = t * obb_pkg::PI_Q30 / 64'd2880;
    x2 = (x * x) >> 30;
    p  = obb_pkg::Q30_ONE;
    for (int i = 0; i < 5; i++) p = obb_pkg::Q30_ONE - ((x2 * p) >> 30) / sdiv[i];
    s = longint'((((x * p) >> 30) + (64'd1 << 14)) >> 15);
    p = obb_pkg::Q30_ONE;
    for (int i = 0; i < 6; i++) p = obb_pkg::Q30_ONE - ((x2 * p) >> 30) / cdiv[i];
    c = longint'((p + (64'd1 << 14)) >> 15);
  endfunction

  function automatic void rot_trig(input logic [12:0] ang,
                                   output longint s, output longint c);
    int unsigned a, r;
    obb_pkg::quad_t q;
    longint bs, bc;
    a = 32'(ang) % 5760;
    q = obb_pkg::quad_t'(a / 1440);
    r = a % 1440;
    if (r <= 720) octant_trig(64'(r), bs, bc);
    else octant_trig(64'(1440 - r), bc, bs);
    case (q)
      obb_pkg::QUAD_0: begin s = bs;  c = bc;  end
      obb_pkg::QUAD_1: begin s = bc;  c = -bs; end
      obb_pkg::QUAD_2: begin s = -bs; c = -bc; end
      default: begin s = -bc; c = bs; end
    endcase
  endfunction

  function automatic acc_t abs_dot(input longint ax, ay, bx, by);
    acc_t v;
    v = acc_t'(ax) * acc_t'(bx) + acc_t'(ay) * acc_t'(by);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit predict_overlap(input box_pair_t p);
    longint vx[4], vy[4];
    longint sa, ca, sb, cb, dx, dy;
    longint aw, ah, bw, bh;
    acc_t lhs, sum;
    aw = longint'(p.a_width);  ah = longint'(p.a_height);
    bw = longint'(p.b_width);  bh = longint'(p.b_height);
    dx = (2 * longint'(p.a_left) + aw) - (2 * longint'(p.b_left) + bw);
    dy = (2 * longint'(p.a_top) + ah) - (2 * longint'(p.b_top) + bh);
    rot_trig(p.a_angle, sa, ca);
    rot_trig(p.b_angle, sb, cb);
    vx[0] = ah * sa;  vy[0] = -(ah * ca);
    vx[1] = bh * sb;  vy[1] = -(bh * cb);
    vx[2] = aw * ca;  vy[2] = aw * sa;
    vx[3] = bw * cb;  vy[3] = bw * sb;
    for (int i = 0; i < 4; i++) begin
      lhs = abs_dot(dx, dy, vx[i], vy[i]) <<< 15;
      sum = 0;
      for (int j = 0; j < 4; j++) sum += abs_dot(vx[j], vy[j], vx[i], vy[i]);
      if (lhs > sum) return 1'b0;  // separating axis; equality still touches
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Driving and checking
  // --------------------------------------------------------------------------

  // One box pair transfer; the flag is predicted when the pair is accepted.
  task automatic send_pair(input box_pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      boxes.valid <= 1'b0;
      @(posedge clk);
    end
    boxes.a_left   <= p.a_left;   boxes.a_top    <= p.a_top;
    boxes.a_width  <= p.a_width;  boxes.a_height <= p.a_height;
    boxes.a_angle  <= p.a_angle;
    boxes.b_left   <= p.b_left;   boxes.b_top    <= p.b_top;
    boxes.b_width  <= p.b_width;  boxes.b_height <= p.b_height;
    boxes.b_angle  <= p.b_angle;
    boxes.valid    <= 1'b1;
    do @(posedge clk); while (!boxes.ready);
    overlap_q.push_back(predict_overlap(p));
  endtask

  // Receiver: random backpressure plus in-order flag check.
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (overlap_q.size() == 0) begin
          $display("%0t: unexpected overlap transfer, actual %0b", $time, result.overlap);
          errors++;
        end else begin
          bit want;
          want = overlap_q.pop_front();
          if (result.overlap !== want) begin
            $display("%0t: overlap mismatch, expected %0b actual %0b",
                     $time, want, result.overlap);
            errors++;
          end
        end
      end
      result.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic box_pair_t make_pair(input int al, at, int aw, ah, aa,
                                          input int bl, bt, int bw, bh, ba);
    box_pair_t p;
    p.a_left = 16'(al);  p.a_top = 16'(at);
    p.a_width = 13'(aw);  p.a_height = 13'(ah);  p.a_angle = 13'(aa);
    p.b_left = 16'(bl);  p.b_top = 16'(bt);
    p.b_width = 13'(bw);  p.b_height = 13'(bh);  p.b_angle = 13'(ba);
    return p;
  endfunction

  // Mostly nearby pairs so both outcomes are common; some raw bit noise.
  function automatic box_pair_t random_pair();
    box_pair_t p;
    int mode;
    mode = $urandom_range(9);
    p.a_left = 16'($urandom);  p.a_top = 16'($urandom);
    p.a_width = 13'($urandom); p.a_height = 13'($urandom); p.a_angle = 13'($urandom);
    p.b_left = 16'($urandom);  p.b_top = 16'($urandom);
    p.b_width = 13'($urandom); p.b_height = 13'($urandom); p.b_angle = 13'($urandom);
    if (mode >= 2) begin
      if (mode < 8) begin
        p.a_width = 13'($urandom_range(300));  p.a_height = 13'($urandom_range(300));
        p.b_width = 13'($urandom_range(300));  p.b_height = 13'($urandom_range(300));
      end
      p.a_angle = 13'($urandom_range(5759));
      p.b_angle = (mode == 9) ? 13'($urandom_range(8191)) : 13'($urandom_range(5759));
      p.b_left  = p.a_left + $signed(16'($urandom_range(800))) - 16'sd400;
      p.b_top   = p.a_top  + $signed(16'($urandom_range(800))) - 16'sd400;
    end
    return p;
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    while (overlap_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (obb_pkg::LATENCY + 4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, angle wrap, zero-length edges, touching edges.
  task automatic test_directed();
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));             // all sides zero
    send_pair(make_pair(-32768, -32768, 0, 0, 0, 32767, 32767, 0, 0, 0));
    send_pair(make_pair(0, 0, 10, 10, 0, 10, 0, 10, 10, 0));         // touching on x
    send_pair(make_pair(0, 0, 10, 10, 0, 11, 0, 10, 10, 0));         // one pixel gap
    send_pair(make_pair(0, 0, 10, 10, 0, 0, 10, 10, 10, 0));         // touching on y
    send_pair(make_pair(-32768, -32768, 8191, 8191, 5759,
                        32767, 32767, 8191, 8191, 5759));
    send_pair(make_pair(32767, 32767, 8191, 8191, 0,
                        -32768, -32768, 8191, 8191, 0));             // opposite coordinate extremes
    send_pair(make_pair(0, 0, 100, 0, 720, 50, 0, 0, 100, 1440));    // zero heights/widths
    send_pair(make_pair(0, 0, 100, 20, 5760, 0, 0, 100, 20, 8191));  // wrapped angles
    send_pair(make_pair(0, 0, 100, 20, 7200, 150, 0, 20, 100, 2880));
    send_pair(make_pair(0, 0, 100, 100, 720, 130, 0, 100, 100, 0));  // 45 degree corner
    send_pair(make_pair(0, 0, 100, 100, 720, 125, 0, 100, 100, 0));
    send_pair(make_pair(0, 0, 40, 10, 1440, 0, 0, 40, 10, 4320));
    send_pair(make_pair(5, 5, 1, 1, 2880, 5, 5, 1, 1, 8190));
    send_pair(make_pair(-100, 50, 8191, 1, 360, 200, -70, 1, 8191, 1080));
    send_pair(make_pair(0, 0, 8191, 8191, 5759, 0, 0, 0, 0, 5759));
    boxes.valid <= 1'b0;
    drain();
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (n) send_pair(random_pair());
    boxes.valid <= 1'b0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    boxes.valid = 1'b0;
    boxes.a_left = '0;  boxes.a_top = '0;  boxes.a_width = '0;
    boxes.a_height = '0; boxes.a_angle = '0;
    boxes.b_left = '0;  boxes.b_top = '0;  boxes.b_width = '0;
    boxes.b_height = '0; boxes.b_angle = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(380, 0, 0);     // full rate
    test_random(360, 87, 0);    // sparse sender
    test_random(360, 0, 87);    // heavy backpressure
    test_random(350, 34, 34);   // both sides idle

    if (errors == 0 && overlap_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
